/* rtl/residual_norms_engine_defines.svh */
// ----------------------------------------------------------------------------
// residual_norms_engine_defines
// Assertion macros shared by the residual norms engine.
// ----------------------------------------------------------------------------
`ifndef RESIDUAL_NORMS_ENGINE_DEFINES_SVH
`define RESIDUAL_NORMS_ENGINE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define RNE_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rne assertion failed");

// next-cycle implication, checked outside reset
`define RNE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rne assertion failed");

`endif

/* rtl/rne_pkg.sv */
// ----------------------------------------------------------------------------
// rne_pkg
// Types and constants of the residual norms engine.
// ----------------------------------------------------------------------------
package rne_pkg;

  localparam int ACC_W   = 39;  // row dot product, signed Q.24
  localparam int DIFF_W  = 40;  // dot minus b, signed Q.24
  localparam int RES_W   = 24;  // residual, unsigned Q12.12
  localparam int ONE_W   = 30;
  localparam int SQ_W    = 2 * RES_W;
  localparam int SQS_W   = 54;
  localparam int TWO_W   = 27;
  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic signed [15:0] a_elem;
    logic signed [15:0] x_elem;
    logic signed [15:0] b_elem;
    logic               row_end;
    logic               matrix_end;
  } in_item_t;

  typedef struct packed {
    logic [ONE_W-1:0] norm_one;
    logic [TWO_W-1:0] norm_two;
    logic [RES_W-1:0] norm_inf;
    logic             saturated;
  } out_item_t;

  // one closed row, handed from front to back
  typedef struct packed {
    logic [RES_W-1:0] residual;
    logic             sat;
    logic             mend;
  } res_rec_t;

  typedef struct packed {
    logic [QCNT_W-1:0] count;
    logic              nonempty;
  } q_stat_t;

endpackage

/* rtl/rne_front.sv */
// ----------------------------------------------------------------------------
// rne_front
// Element stream front end: products, row accumulation, residual per row.
// ----------------------------------------------------------------------------
module rne_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  rne_pkg::in_item_t in_data,
  input  rne_pkg::q_stat_t  q_stat,
  output logic              push_v,
  output rne_pkg::res_rec_t push_rec
);
  import rne_pkg::*;

  logic                     s1_v_r, s1_close_r, s1_mend_r;
  logic signed [31:0]       prod_r;
  logic [15:0]              s1_b_r;
  logic [ACC_W-1:0]         acc_r, acc_nxt;
  logic                     s2_v_r, s2_mend_r;
  logic [ACC_W-1:0]         s2_acc_r;
  logic [15:0]              s2_b_r;
  logic                     s3_v_r, s3_mend_r;
  logic [DIFF_W-1:0]        s3_diff_r;
  logic [DIFF_W-1:0]        sum40;
  logic [ACC_W-1:0]         acc_sat;
  logic [DIFF_W-1:0]        diff_nxt;
  logic                     neg;
  logic [DIFF_W-1:0]        mag_sel;
  logic [DIFF_W:0]          rnd;
  logic [DIFF_W-12:0]       r_full;
  logic                     r_sat;
  logic [QCNT_W+1:0]        pending;
  logic                     accept;

  // every row close in flight holds a queue slot
  assign pending = {2'b00, q_stat.count} + (QCNT_W+2)'(s1_v_r & s1_close_r)
                 + (QCNT_W+2)'(s2_v_r) + (QCNT_W+2)'(s3_v_r);
  assign in_ready = pending < (QCNT_W+2)'(QDEPTH);
  assign accept   = in_valid & in_ready;

  // accumulate with saturation at the 39-bit signed limits
  assign sum40 = {acc_r[ACC_W-1], acc_r} + {{(DIFF_W-32){prod_r[31]}}, prod_r};
  always_comb begin
    if (sum40[DIFF_W-1] == sum40[DIFF_W-2]) begin
      acc_sat = sum40[ACC_W-1:0];
    end else if (!sum40[DIFF_W-1]) begin
      acc_sat = {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      acc_sat = {1'b1, {(ACC_W-1){1'b0}}};
    end
  end

  always_comb begin
    acc_nxt = acc_r;
    if (s1_v_r) begin
      acc_nxt = s1_close_r ? '0 : acc_sat;
    end
  end

  assign diff_nxt = {s2_acc_r[ACC_W-1], s2_acc_r}
                  - {{(DIFF_W-28){s2_b_r[15]}}, s2_b_r, 12'b0};

  // |diff| rounded half up: for negative diff, -diff + 2048 = ~diff + 2049
  assign neg     = s3_diff_r[DIFF_W-1];
  assign mag_sel = neg ? ~s3_diff_r : s3_diff_r;
  assign rnd     = {1'b0, mag_sel} + (neg ? (DIFF_W+1)'(2049) : (DIFF_W+1)'(2048));
  assign r_full  = rnd[DIFF_W:12];
  assign r_sat   = |r_full[DIFF_W-12:RES_W];

  assign push_v            = s3_v_r;
  assign push_rec.residual = r_sat ? {RES_W{1'b1}} : r_full[RES_W-1:0];
  assign push_rec.sat      = r_sat;
  assign push_rec.mend     = s3_mend_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      acc_r  <= '0;
    end else begin
      s1_v_r <= accept;
      s2_v_r <= s1_v_r & s1_close_r;
      s3_v_r <= s2_v_r;
      acc_r  <= acc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      prod_r     <= in_data.a_elem * in_data.x_elem;
      s1_b_r     <= in_data.b_elem;
      s1_close_r <= in_data.row_end | in_data.matrix_end;
      s1_mend_r  <= in_data.matrix_end;
    end
    if (s1_v_r && s1_close_r) begin
      s2_acc_r  <= acc_sat;
      s2_b_r    <= s1_b_r;
      s2_mend_r <= s1_mend_r;
    end
    if (s2_v_r) begin
      s3_diff_r <= diff_nxt;
      s3_mend_r <= s2_mend_r;
    end
  end

endmodule

/* rtl/rne_queue.sv */
// ----------------------------------------------------------------------------
// rne_queue
// Small FIFO of closed-row records between front and back.
// ----------------------------------------------------------------------------
module rne_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_v,
  input  rne_pkg::res_rec_t push_rec,
  input  logic              pop,
  output rne_pkg::res_rec_t head_rec,
  output rne_pkg::q_stat_t  q_stat
);
  import rne_pkg::*;

  res_rec_t          q_mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] count_r, count_nxt;

  always_comb begin
    count_nxt = count_r;
    if (push_v && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push_v) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push_v) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_v) begin
      q_mem_r[wr_ptr_r] <= push_rec;
    end
  end

  assign head_rec        = q_mem_r[rd_ptr_r];
  assign q_stat.count    = count_r;
  assign q_stat.nonempty = count_r != '0;

endmodule

/* rtl/rne_back.sv */
// ----------------------------------------------------------------------------
// rne_back
// Norm accumulation, iterative square root and result register.
// ----------------------------------------------------------------------------
module rne_back (
  input  logic               clk,
  input  logic               rst_n,
  input  rne_pkg::res_rec_t  head_rec,
  input  rne_pkg::q_stat_t   q_stat,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output rne_pkg::out_item_t out_data
);
  import rne_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_MUL  = 5'b00010,
    ST_ACC  = 5'b00100,
    ST_SQRT = 5'b01000,
    ST_DONE = 5'b10000
  } bst_t;

  bst_t             st_r, st_nxt;
  res_rec_t         rec_r;
  logic [SQ_W-1:0]  sq_r;
  logic [ONE_W-1:0] abs_sum_r;
  logic [SQS_W-1:0] sq_sum_r;
  logic [RES_W-1:0] max_r;
  logic             sat_r;
  logic [ONE_W-1:0] h_one_r;
  logic [RES_W-1:0] h_inf_r;
  logic             h_sat_r;
  logic [SQS_W-1:0] sq_val_r;
  logic [TWO_W:0]   rem_r;
  logic [TWO_W-1:0] root_r;
  logic [4:0]       step_r;
  logic             out_valid_r;
  out_item_t        out_data_r;

  logic [ONE_W:0]   s1;
  logic [SQS_W:0]   s2;
  logic [ONE_W-1:0] abs_n;
  logic [SQS_W-1:0] sq_n;
  logic [RES_W-1:0] max_n;
  logic             sat_n;
  logic [TWO_W+2:0] rem_sh, trial;
  logic             ge;
  logic             out_load;

  assign s1    = {1'b0, abs_sum_r} + (ONE_W+1)'(rec_r.residual);
  assign abs_n = s1[ONE_W] ? {ONE_W{1'b1}} : s1[ONE_W-1:0];
  assign s2    = {1'b0, sq_sum_r} + (SQS_W+1)'(sq_r);
  assign sq_n  = s2[SQS_W] ? {SQS_W{1'b1}} : s2[SQS_W-1:0];
  assign max_n = (rec_r.residual > max_r) ? rec_r.residual : max_r;
  assign sat_n = sat_r | rec_r.sat;

  // restoring square root, two radicand bits per step
  assign rem_sh = {rem_r, sq_val_r[SQS_W-1:SQS_W-2]};
  assign trial  = {1'b0, root_r, 2'b01};
  assign ge     = rem_sh >= trial;

  assign pop      = (st_r == ST_IDLE) && q_stat.nonempty;
  assign out_load = (st_r == ST_DONE) && (!out_valid_r || out_ready);

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE: if (q_stat.nonempty) st_nxt = ST_MUL;
      ST_MUL:  st_nxt = ST_ACC;
      ST_ACC:  st_nxt = rec_r.mend ? ST_SQRT : ST_IDLE;
      ST_SQRT: if (step_r == 5'(TWO_W - 1)) st_nxt = ST_DONE;
      ST_DONE: if (out_load) st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      out_valid_r <= 1'b0;
      abs_sum_r   <= '0;
      sq_sum_r    <= '0;
      max_r       <= '0;
      sat_r       <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (st_r == ST_ACC) begin
        if (rec_r.mend) begin
          abs_sum_r <= '0;
          sq_sum_r  <= '0;
          max_r     <= '0;
          sat_r     <= 1'b0;
        end else begin
          abs_sum_r <= abs_n;
          sq_sum_r  <= sq_n;
          max_r     <= max_n;
          sat_r     <= sat_n;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      rec_r <= head_rec;
    end
    if (st_r == ST_MUL) begin
      sq_r <= rec_r.residual * rec_r.residual;
    end
    if (st_r == ST_ACC && rec_r.mend) begin
      h_one_r  <= abs_n;
      h_inf_r  <= max_n;
      h_sat_r  <= sat_n;
      sq_val_r <= sq_n;
      rem_r    <= '0;
      root_r   <= '0;
      step_r   <= '0;
    end
    if (st_r == ST_SQRT) begin
      rem_r    <= ge ? (TWO_W+1)'(rem_sh - trial) : rem_sh[TWO_W:0];
      root_r   <= {root_r[TWO_W-2:0], ge};
      sq_val_r <= {sq_val_r[SQS_W-3:0], 2'b00};
      step_r   <= step_r + 1'b1;
    end
    if (out_load) begin
      out_data_r.norm_one  <= h_one_r;
      out_data_r.norm_two  <= root_r;
      out_data_r.norm_inf  <= h_inf_r;
      out_data_r.saturated <= h_sat_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* rtl/residual_norms_engine.sv */
// ----------------------------------------------------------------------------
// residual_norms_engine
// 1-, 2- and infinity-norms of the residual Ax-b over a streamed matrix.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready/in_data): one item per matrix element with
// the matching x element; the item with row_end carries b for that row and
// the item with matrix_end closes the matrix. Elements are taken at one per
// cycle while in_ready is high; the front multiplies, accumulates and forms
// each row's residual in a three-stage pipeline and drops it into a
// four-entry queue. The back pops one row record and finishes it before it
// takes the next (square on the multiplier, then saturating sums and max).
// On a matrix end it runs a restoring square root, one result bit per cycle,
// then loads the root with the 1- and infinity-norms into the output register
// on out_valid/out_data. in_ready drops only when queued plus in-flight row
// closes fill the queue. Result channel: held in an output register; while
// the receiver stalls the back keeps working on the next matrix until it has
// another result ready. Reset (rst_n low, synchronous) clears all sums,
// pipeline and queue state; norm sums and max clear again at each matrix end.
// ----------------------------------------------------------------------------
`include "residual_norms_engine_defines.svh"

module residual_norms_engine (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  rne_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output rne_pkg::out_item_t out_data
);
  import rne_pkg::*;

  logic     push_v;
  res_rec_t push_rec;
  res_rec_t head_rec;
  q_stat_t  q_stat;
  logic     pop;

  rne_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_stat   (q_stat),
    .push_v   (push_v),
    .push_rec (push_rec)
  );

  rne_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push_v   (push_v),
    .push_rec (push_rec),
    .pop      (pop),
    .head_rec (head_rec),
    .q_stat   (q_stat)
  );

  rne_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head_rec  (head_rec),
    .q_stat    (q_stat),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  `RNE_ASSERT_NOW(a_accept_room, in_valid && in_ready, q_stat.count < QCNT_W'(QDEPTH))
  `RNE_ASSERT_NOW(a_push_room, push_v, q_stat.count < QCNT_W'(QDEPTH) || pop)
  `RNE_ASSERT_NOW(a_pop_nonempty, pop, q_stat.nonempty)
  `RNE_ASSERT_NEXT(a_pop_busy, pop, !pop)

endmodule
